// File: sv/tpi_pkg.sv
// Shared constants and types for the three-plane intersection block.
// No dependencies; imported by three_plane_intersection_top, tpi_checker and the testbench.
package tpi_pkg;

  // Fixed-point formats
  localparam int NORMAL_FRAC_BITS = 16;
  localparam int COORD_FRAC_BITS  = 8;
  localparam int NORM_W  = 18;
  localparam int DIST_W  = 24;
  localparam int COORD_W = 24;
  localparam int THR_W   = 52;
  localparam logic [THR_W-1:0] THR_RESET = 52'd281474976711;

  // Datapath widths
  localparam int PROD_W  = 2 * NORM_W;         // normal x normal
  localparam int COF_W   = PROD_W + 1;         // cofactor (difference)
  localparam int DTERM_W = COF_W + NORM_W;     // cofactor x normal
  localparam int DET_W   = DTERM_W + 2;        // sum of three
  localparam int NTERM_W = COF_W + DIST_W;     // cofactor x distance
  localparam int NUM_W   = NTERM_W + 2;        // sum of three

  // Quotient scaling: numerator at 2N+C, determinant at 3N, result at C
  localparam int QUOT_SHIFT = 3 * NORMAL_FRAC_BITS
                              - (2 * NORMAL_FRAC_BITS + COORD_FRAC_BITS) + COORD_FRAC_BITS;
  localparam int OVF_SH    = COORD_W - QUOT_SHIFT;
  localparam int DIV_STEPS = COORD_W;

  // Saturation limits
  localparam logic [COORD_W:0]   Q_LIM   = (COORD_W+1)'(1) << (COORD_W - 1);
  localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Register map
  localparam int APB_AW = 4;
  localparam int APB_DW = 64;
  localparam logic [APB_AW-1:0] REG_THR_ADDR = 4'd0;

  // One coordinate in flight through the divider
  typedef struct packed {
    logic [DET_W-1:0]   rem;
    logic [COORD_W-1:0] quo;
    logic [COORD_W-1:0] feed;
    logic               neg;
    logic               ovf;
  } tpi_div_t;

  // One result item
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               found;
    logic               sat;
  } tpi_res_t;

endpackage

// File: sv/three_plane_intersection_top.sv
// Three-plane intersection (Cramer's rule), fully pipelined top level.
// Depends on tpi_pkg.
//
// Accepts one plane triple per cycle while in_ready_o is high and returns one result
// item per triple, in order. Arithmetic stages (products, cofactors, determinant and
// numerator products, sums, magnitudes, threshold and overflow check) are followed
// by a 24-stage restoring divider, one quotient bit per stage, and a rounding/saturation
// stage into the output register.
// A skid register behind the output lets the pipeline keep moving for one item
// while a result waits; throughput is one item per cycle while out_ready_i is high.
// singular_threshold is at byte address 0 (64-bit APB data) and is read each item
// at the threshold stage, so change it only while the block is idle.
module three_plane_intersection_top
  import tpi_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // APB configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready,
  // Input item
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [NORM_W-1:0]  plane0_normal_x_i,
  input  logic signed [NORM_W-1:0]  plane0_normal_y_i,
  input  logic signed [NORM_W-1:0]  plane0_normal_z_i,
  input  logic signed [DIST_W-1:0]  plane0_distance_i,
  input  logic signed [NORM_W-1:0]  plane1_normal_x_i,
  input  logic signed [NORM_W-1:0]  plane1_normal_y_i,
  input  logic signed [NORM_W-1:0]  plane1_normal_z_i,
  input  logic signed [DIST_W-1:0]  plane1_distance_i,
  input  logic signed [NORM_W-1:0]  plane2_normal_x_i,
  input  logic signed [NORM_W-1:0]  plane2_normal_y_i,
  input  logic signed [NORM_W-1:0]  plane2_normal_z_i,
  input  logic signed [DIST_W-1:0]  plane2_distance_i,
  // Result item
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] point_x_o,
  output logic signed [COORD_W-1:0] point_y_o,
  output logic signed [COORD_W-1:0] point_z_o,
  output logic                      point_found_o,
  output logic                      coord_saturated_o
);

  localparam int ST_DIV = 6;                    // divider init stage
  localparam int NSTG   = ST_DIV + DIV_STEPS + 1;

  // ---------------- configuration register ----------------
  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && paddr == REG_THR_ADDR) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_THR_ADDR) ? {{(APB_DW-THR_W){1'b0}}, thr_q} : '0;

  // ---------------- pipeline control ----------------
  logic            adv;
  logic [NSTG-1:0] v_q;
  logic            skid_v_q;
  logic            out_v_q;
  tpi_res_t        skid_q, out_q, res;

  assign adv        = !skid_v_q;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // ---------------- stage registers ----------------
  logic signed [NORM_W-1:0]  s0_n_q [3][3];
  logic signed [DIST_W-1:0]  s0_d_q [3];
  logic signed [PROD_W-1:0]  s1_pp_q [3][3][2];
  logic signed [NORM_W-1:0]  s1_nx_q [3];
  logic signed [DIST_W-1:0]  s1_d_q [3];
  logic signed [COF_W-1:0]   s2_cof_q [3][3];
  logic signed [NORM_W-1:0]  s2_nx_q [3];
  logic signed [DIST_W-1:0]  s2_d_q [3];
  logic signed [DTERM_W-1:0] s3_dt_q [3];
  logic signed [NTERM_W-1:0] s3_nt_q [3][3];
  logic signed [DET_W-1:0]   s4_det_q;
  logic signed [NUM_W-1:0]   s4_num_q [3];
  logic [DET_W-1:0]          s5_dmag_q;
  logic [NUM_W-1:0]          s5_nmag_q [3];
  logic                      s5_neg_q [3];
  tpi_div_t                  dv_q [DIV_STEPS+1][3];
  tpi_div_t                  dv_d [DIV_STEPS+1][3];
  logic [DET_W-1:0]          dmag_q [DIV_STEPS+1];
  logic                      fnd_q [DIV_STEPS+1];

  // Arithmetic stages ahead of the divider
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // input capture
      s0_n_q[0][0] <= plane0_normal_x_i;
      s0_n_q[0][1] <= plane0_normal_y_i;
      s0_n_q[0][2] <= plane0_normal_z_i;
      s0_n_q[1][0] <= plane1_normal_x_i;
      s0_n_q[1][1] <= plane1_normal_y_i;
      s0_n_q[1][2] <= plane1_normal_z_i;
      s0_n_q[2][0] <= plane2_normal_x_i;
      s0_n_q[2][1] <= plane2_normal_y_i;
      s0_n_q[2][2] <= plane2_normal_z_i;
      s0_d_q[0]    <= plane0_distance_i;
      s0_d_q[1]    <= plane1_distance_i;
      s0_d_q[2]    <= plane2_distance_i;
      // cofactor products: column c uses axes (c+1, c+2), row k uses planes (k+1, k+2)
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          s1_pp_q[c][k][0] <= s0_n_q[(k+1)%3][(c+1)%3] * s0_n_q[(k+2)%3][(c+2)%3];
          s1_pp_q[c][k][1] <= s0_n_q[(k+2)%3][(c+1)%3] * s0_n_q[(k+1)%3][(c+2)%3];
        end
      end
      for (int k = 0; k < 3; k++) begin
        s1_nx_q[k] <= s0_n_q[k][0];
        s1_d_q[k]  <= s0_d_q[k];
        s2_nx_q[k] <= s1_nx_q[k];
        s2_d_q[k]  <= s1_d_q[k];
      end
      // cofactors
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          s2_cof_q[c][k] <= COF_W'(s1_pp_q[c][k][0]) - COF_W'(s1_pp_q[c][k][1]);
        end
      end
      // determinant terms and numerator terms
      for (int k = 0; k < 3; k++) begin
        s3_dt_q[k] <= s2_cof_q[0][k] * s2_nx_q[k];
        for (int c = 0; c < 3; c++) begin
          s3_nt_q[c][k] <= s2_cof_q[c][k] * s2_d_q[k];
        end
      end
      // sums
      s4_det_q <= DET_W'(s3_dt_q[0]) + DET_W'(s3_dt_q[1]) + DET_W'(s3_dt_q[2]);
      for (int c = 0; c < 3; c++) begin
        s4_num_q[c] <= NUM_W'(s3_nt_q[c][0]) + NUM_W'(s3_nt_q[c][1])
                       + NUM_W'(s3_nt_q[c][2]);
      end
      // magnitudes and quotient signs
      s5_dmag_q <= s4_det_q[DET_W-1] ? DET_W'(-s4_det_q) : DET_W'(s4_det_q);
      for (int c = 0; c < 3; c++) begin
        s5_nmag_q[c] <= s4_num_q[c][NUM_W-1] ? NUM_W'(-s4_num_q[c]) : NUM_W'(s4_num_q[c]);
        s5_neg_q[c]  <= s4_num_q[c][NUM_W-1] ^ s4_det_q[DET_W-1];
      end
    end
  end

  // Divider init and restoring steps, one quotient bit per stage
  always_comb begin
    logic [DET_W:0] t;
    for (int c = 0; c < 3; c++) begin
      dv_d[0][c].ovf  = {{(DET_W+OVF_SH-NUM_W){1'b0}}, s5_nmag_q[c]}
                        >= {s5_dmag_q, {OVF_SH{1'b0}}};
      dv_d[0][c].rem  = {{(DET_W-NUM_W+OVF_SH){1'b0}}, s5_nmag_q[c][NUM_W-1:OVF_SH]};
      dv_d[0][c].feed = {s5_nmag_q[c][OVF_SH-1:0], {QUOT_SHIFT{1'b0}}};
      dv_d[0][c].quo  = '0;
      dv_d[0][c].neg  = s5_neg_q[c];
    end
    for (int j = 1; j <= DIV_STEPS; j++) begin
      for (int c = 0; c < 3; c++) begin
        t = {dv_q[j-1][c].rem, dv_q[j-1][c].feed[COORD_W-1]};
        dv_d[j][c] = dv_q[j-1][c];
        dv_d[j][c].feed = {dv_q[j-1][c].feed[COORD_W-2:0], 1'b0};
        if (t >= {1'b0, dmag_q[j-1]}) begin
          dv_d[j][c].rem = DET_W'(t - {1'b0, dmag_q[j-1]});
          dv_d[j][c].quo = {dv_q[j-1][c].quo[COORD_W-2:0], 1'b1};
        end else begin
          dv_d[j][c].rem = t[DET_W-1:0];
          dv_d[j][c].quo = {dv_q[j-1][c].quo[COORD_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dmag_q[0] <= s5_dmag_q;
      fnd_q[0]  <= (s5_dmag_q != '0) && (s5_dmag_q >= {{(DET_W-THR_W){1'b0}}, thr_q});
      for (int j = 0; j <= DIV_STEPS; j++) begin
        for (int c = 0; c < 3; c++) begin
          dv_q[j][c] <= dv_d[j][c];
        end
      end
      for (int j = 1; j <= DIV_STEPS; j++) begin
        dmag_q[j] <= dmag_q[j-1];
        fnd_q[j]  <= fnd_q[j-1];
      end
    end
  end

  // ---------------- rounding and saturation ----------------
  always_comb begin
    logic [COORD_W:0]   qr;
    logic               rnd, sat_c;
    logic [COORD_W-1:0] val [3];
    logic               any_sat;
    any_sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      rnd   = {dv_q[DIV_STEPS][c].rem, 1'b0} >= {1'b0, dmag_q[DIV_STEPS]};
      qr    = {1'b0, dv_q[DIV_STEPS][c].quo} + (COORD_W+1)'(rnd);
      sat_c = dv_q[DIV_STEPS][c].ovf
              || (dv_q[DIV_STEPS][c].neg ? (qr > Q_LIM) : (qr > Q_LIM - 1'b1));
      if (sat_c) begin
        val[c] = dv_q[DIV_STEPS][c].neg ? NEG_MIN : POS_MAX;
      end else begin
        val[c] = dv_q[DIV_STEPS][c].neg ? COORD_W'(-qr) : qr[COORD_W-1:0];
      end
      any_sat = any_sat | sat_c;
    end
    if (fnd_q[DIV_STEPS]) begin
      res.x     = val[0];
      res.y     = val[1];
      res.z     = val[2];
      res.found = 1'b1;
      res.sat   = any_sat;
    end else begin
      res = '0;
    end
  end

  // ---------------- output register with skid ----------------
  logic emerge;
  assign emerge = adv && v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= emerge;
      end
    end else if (emerge) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (emerge) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_v_q;
  assign point_x_o         = out_q.x;
  assign point_y_o         = out_q.y;
  assign point_z_o         = out_q.z;
  assign point_found_o     = out_q.found;
  assign coord_saturated_o = out_q.sat;

endmodule

// File: dv/tpi_checker.sv
// Checker for the three-plane intersection block: predicts each result from
// the accepted plane triples and compares it with the result channel.
// Depends on tpi_pkg.
`timescale 1ns / 100ps
module tpi_checker
  import tpi_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_i,
  input  logic [THR_W-1:0]          cfg_thr_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [NORM_W-1:0]  nrm_i [9],
  input  logic signed [DIST_W-1:0]  dist_i [3],
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  input  logic                      point_found_i,
  input  logic                      coord_saturated_i,
  output int                        errors_o,
  output int                        pending_o,
  output int                        found_cnt_o,
  output int                        sat_cnt_o
);

  logic [THR_W-1:0] thr_q;
  tpi_res_t         points_q[$];

  // Rounded, saturated quotient num * 2^QUOT_SHIFT / den
  function automatic logic signed [COORD_W-1:0] solve_coord(
      input logic signed [127:0] num, input logic signed [127:0] den,
      inout logic sat);
    logic [127:0] n, d, q, r;
    logic         neg;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    n = n << QUOT_SHIFT;
    neg = (num < 0) != (den < 0);
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    if (neg) begin
      if (q > 128'(1) << (COORD_W - 1)) begin
        sat = 1'b1;
        return NEG_MIN;
      end
      return COORD_W'(-q);
    end
    if (q > (128'(1) << (COORD_W - 1)) - 1) begin
      sat = 1'b1;
      return POS_MAX;
    end
    return COORD_W'(q);
  endfunction

  // Cramer's rule on one plane triple
  function automatic tpi_res_t solve_planes(
      input logic signed [NORM_W-1:0] m [9], input logic signed [DIST_W-1:0] dv [3]);
    logic signed [127:0] n [3][3];
    logic signed [127:0] dd [3];
    logic signed [127:0] a0, a1, a2, b0, b1, b2, c0, c1, c2, det;
    logic [127:0]        dmag;
    tpi_res_t            res;
    logic                sat;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) n[k][j] = m[k*3+j];
      dd[k] = dv[k];
    end
    a0 = n[1][1]*n[2][2] - n[2][1]*n[1][2];
    a1 = n[2][1]*n[0][2] - n[0][1]*n[2][2];
    a2 = n[0][1]*n[1][2] - n[1][1]*n[0][2];
    b0 = n[1][2]*n[2][0] - n[2][2]*n[1][0];
    b1 = n[2][2]*n[0][0] - n[0][2]*n[2][0];
    b2 = n[0][2]*n[1][0] - n[1][2]*n[0][0];
    c0 = n[1][0]*n[2][1] - n[2][0]*n[1][1];
    c1 = n[2][0]*n[0][1] - n[0][0]*n[2][1];
    c2 = n[0][0]*n[1][1] - n[1][0]*n[0][1];
    det = a0*n[0][0] + a1*n[1][0] + a2*n[2][0];
    dmag = det < 0 ? -det : det;
    res = '0;
    sat = 1'b0;
    if (det == 0 || dmag < {76'd0, thr_q}) return res;
    res.x = solve_coord(a0*dd[0] + a1*dd[1] + a2*dd[2], det, sat);
    res.y = solve_coord(b0*dd[0] + b1*dd[1] + b2*dd[2], det, sat);
    res.z = solve_coord(c0*dd[0] + c1*dd[1] + c2*dd[2], det, sat);
    res.found = 1'b1;
    res.sat = sat;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tpi_res_t want;
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      points_q.delete();
      errors_o = 0;
      found_cnt_o = 0;
      sat_cnt_o = 0;
    end else begin
      // Result side first; input side predicts with the register as it stands
      if (out_valid_i && out_ready_i) begin
        if (points_q.size() == 0) begin
          $error("result item with nothing expected");
          errors_o++;
        end else begin
          want = points_q.pop_front();
          if (point_x_i !== want.x) begin
            $error("point_x exp %0d got %0d", $signed(want.x), point_x_i); errors_o++;
          end
          if (point_y_i !== want.y) begin
            $error("point_y exp %0d got %0d", $signed(want.y), point_y_i); errors_o++;
          end
          if (point_z_i !== want.z) begin
            $error("point_z exp %0d got %0d", $signed(want.z), point_z_i); errors_o++;
          end
          if (point_found_i !== want.found) begin
            $error("point_found exp %0b got %0b", want.found, point_found_i); errors_o++;
          end
          if (coord_saturated_i !== want.sat) begin
            $error("coord_saturated exp %0b got %0b", want.sat, coord_saturated_i);
            errors_o++;
          end
          if (want.found) found_cnt_o++;
          if (want.sat) sat_cnt_o++;
        end
      end
      if (in_valid_i && in_ready_i) points_q = {points_q, solve_planes(nrm_i, dist_i)};
      if (cfg_wr_i) thr_q <= cfg_thr_i;
    end
    pending_o = points_q.size();
  end

endmodule

// File: dv/tb_three_plane_intersection_top.sv
// Testbench top for three_plane_intersection_top: drives plane triples and
// threshold writes, stalls both channels. Depends on tpi_pkg and tpi_checker.
`timescale 1ns / 100ps
module tb_three_plane_intersection_top;
  import tpi_pkg::*;

  localparam int LATENCY = 40;
  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_ready_o, out_valid_o, out_ready_i = 1'b0;
  logic signed [NORM_W-1:0] nrm [9];
  logic signed [DIST_W-1:0] plane_dist [3];
  logic signed [COORD_W-1:0] point_x_o, point_y_o, point_z_o;
  logic point_found_o, coord_saturated_o;
  int errors, pending, found_cnt, sat_cnt, idle_cycles, sent;
  logic hold_off = 1'b0, sink_bursty = 1'b1;

  initial begin
    foreach (nrm[k]) nrm[k] = '0;
    foreach (plane_dist[k]) plane_dist[k] = '0;
  end

  initial forever #6 clk_i = ~clk_i;

  three_plane_intersection_top dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .plane0_normal_x_i(nrm[0]), .plane0_normal_y_i(nrm[1]), .plane0_normal_z_i(nrm[2]),
    .plane0_distance_i(plane_dist[0]),
    .plane1_normal_x_i(nrm[3]), .plane1_normal_y_i(nrm[4]), .plane1_normal_z_i(nrm[5]),
    .plane1_distance_i(plane_dist[1]),
    .plane2_normal_x_i(nrm[6]), .plane2_normal_y_i(nrm[7]), .plane2_normal_z_i(nrm[8]),
    .plane2_distance_i(plane_dist[2]),
    .out_valid_o, .out_ready_i, .point_x_o, .point_y_o, .point_z_o,
    .point_found_o, .coord_saturated_o
  );

  tpi_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_wr_i(psel && penable && pwrite && pready && paddr == REG_THR_ADDR),
    .cfg_thr_i(pwdata[THR_W-1:0]),
    .in_valid_i, .in_ready_i(in_ready_o), .nrm_i(nrm), .dist_i(plane_dist),
    .out_valid_i(out_valid_o), .out_ready_i, .point_x_i(point_x_o),
    .point_y_i(point_y_o), .point_z_i(point_z_o), .point_found_i(point_found_o),
    .coord_saturated_i(coord_saturated_o), .errors_o(errors), .pending_o(pending),
    .found_cnt_o(found_cnt), .sat_cnt_o(sat_cnt)
  );

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) out_ready_i <= 1'b0;
    else if (!sink_bursty) out_ready_i <= 1'b1;
    else out_ready_i <= gap_len() == 0;
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_threshold(input logic [THR_W-1:0] thr);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_THR_ADDR; pwdata <= APB_DW'(thr);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Send one triple; caller sets the fields before the call.
  // Valid stays high after the accept until a gap or a drain drops it.
  task automatic send_planes(input bit no_gap);
    int g;
    g = 0;
    if (!no_gap) g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic rand_planes(input int mode);
    int s;
    foreach (nrm[k]) begin
      case (mode)
        0: nrm[k] = NORM_W'($urandom);
        1: nrm[k] = NORM_W'($signed($urandom_range(8192)) - 4096);
        default: nrm[k] = NORM_W'($signed($urandom_range(131072)) - 65536);
      endcase
    end
    if (mode == 3) begin
      // Nearly parallel: third plane a scaled copy of the first plus small noise
      s = $urandom_range(4) - 2;
      for (int j = 0; j < 3; j++)
        nrm[6+j] = NORM_W'(nrm[j] * (s == 0 ? 1 : s) + $signed($urandom_range(4)) - 2);
    end
    foreach (plane_dist[k]) begin
      if ($urandom_range(3) == 0) plane_dist[k] = DIST_W'($urandom);
      else plane_dist[k] = DIST_W'($signed($urandom_range(8192)) - 4096);
    end
  endtask

  task automatic set_unit(input int sx, input int sy, input int sz);
    foreach (nrm[k]) nrm[k] = '0;
    nrm[0] = NORM_W'(sx); nrm[4] = NORM_W'(sy); nrm[8] = NORM_W'(sz);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      rand_planes($urandom_range(3));
      send_planes(1'b0);
    end
  endtask

  initial begin
    sent = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: identity, extremes, rounding, saturation, parallel planes
    set_unit(65536, 65536, 65536);
    plane_dist[0] = 24'sd256; plane_dist[1] = -24'sd512; plane_dist[2] = 24'sd77;
    send_planes(1'b1);
    plane_dist[0] = 24'sh7FFFFF; plane_dist[1] = 24'sh800000; plane_dist[2] = 24'sd0;
    send_planes(1'b1);
    set_unit(-131072, -131072, -131072);
    plane_dist[0] = 24'sh800000; plane_dist[1] = 24'sh7FFFFF; plane_dist[2] = -24'sd1;
    send_planes(1'b1);
    // small normals: coordinates far out of range, but determinant below the threshold
    set_unit(1, 1, 1);
    plane_dist[0] = 24'sh7FFFFF; plane_dist[1] = 24'sh800000; plane_dist[2] = 24'sd3;
    send_planes(1'b1);
    // rounding cases, with determinants below the default threshold
    set_unit(131071, 2, -2);
    plane_dist[0] = 24'sd1; plane_dist[1] = 24'sd1; plane_dist[2] = -24'sd3;
    send_planes(1'b1);
    set_unit(-2, 2, 2);
    plane_dist[0] = 24'sd3; plane_dist[1] = -24'sd5; plane_dist[2] = 24'sd1;
    send_planes(1'b1);
    // all normals zero, and two equal planes
    foreach (nrm[k]) nrm[k] = '0;
    send_planes(1'b1);
    rand_planes(2);
    for (int j = 0; j < 3; j++) nrm[3+j] = nrm[j];
    send_planes(1'b1);
    // every bit of every field high, then maximum positive values and two minimum normals
    foreach (nrm[k]) nrm[k] = 18'sh3FFFF;
    foreach (plane_dist[k]) plane_dist[k] = 24'shFFFFFF;
    send_planes(1'b1);
    foreach (nrm[k]) nrm[k] = 18'sh1FFFF;
    foreach (plane_dist[k]) plane_dist[k] = 24'sh7FFFFF;
    nrm[1] = 18'sh20000; nrm[5] = 18'sh20000;
    send_planes(1'b1);
    random_phase(10);

    // Threshold zero: only an exact zero determinant is parallel
    drain();
    write_threshold('0);
    foreach (nrm[k]) nrm[k] = '0;
    send_planes(1'b0);
    set_unit(1, 1, 1);
    send_planes(1'b0);
    random_phase(300);

    // Maximum threshold: nearly everything parallel
    drain();
    write_threshold({THR_W{1'b1}});
    set_unit(-131072, -131072, -131072);
    send_planes(1'b0);
    random_phase(100);

    // Mid threshold around typical determinants
    drain();
    write_threshold(52'd1 << 44);
    random_phase(200);

    // Long receiver hold-off while the sender keeps pushing
    drain();
    write_threshold(THR_RESET);
    hold_off <= 1'b1;
    fork
      begin
        for (int i = 0; i < 80; i++) begin
          rand_planes(1);
          send_planes(1'b1);
        end
      end
      begin
        repeat (200) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join

    // Full rate, no idling on either side
    sink_bursty <= 1'b0;
    for (int i = 0; i < 150; i++) begin
      rand_planes($urandom_range(3));
      send_planes(1'b1);
    end
    sink_bursty <= 1'b1;
    random_phase(350);

    drain();
    $display("Sent %0d plane triples over four thresholds; %0d points found, %0d saturated.",
             sent, found_cnt, sat_cnt);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/tpi_pkg.sv
sv/three_plane_intersection_top.sv
dv/tpi_checker.sv
dv/tb_three_plane_intersection_top.sv
